// ----- rtl/masg_pkg.sv -----
// Package with shared constants, types and helpers for the multi-axis step generator.
package masg_pkg;

  localparam int unsigned NumAxes        = 4;
  localparam int unsigned DefPosWidth    = 32;
  localparam int unsigned DefFracBits    = 8;
  localparam int unsigned IvlWidth       = 32;
  localparam int unsigned PeriodWidth    = 24;
  localparam int unsigned ModeWidth      = 2;
  localparam int unsigned InDataWidth    = 224;
  localparam int unsigned OutDataWidth   = 40;

  localparam logic [ModeWidth-1:0] AccelConst = 2'd0;
  localparam logic [ModeWidth-1:0] AccelCount = 2'd1;
  localparam logic [ModeWidth-1:0] AccelRamp  = 2'd2;

  localparam logic [1:0] PhaseUp   = 2'd0;
  localparam logic [1:0] PhaseMax  = 2'd1;
  localparam logic [1:0] PhaseDown = 2'd2;

  localparam logic ItemLoad = 1'b0;
  localparam logic ItemTick = 1'b1;

  // Request and reply between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

// ----- rtl/masg_divider.sv -----
// Shared signed 32-bit restoring divider, one quotient bit per cycle.
module masg_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  masg_pkg::div_req_t req_i,
  output masg_pkg::div_rsp_t rsp_o
);
  import masg_pkg::*;

  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d, busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign shifted = {rem_q[30:0], quo_q[31]};
  assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

  // One restoring step per cycle on magnitudes; sign fixed at the end.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[31] ? (32'd0 - req_i.divisor) : req_i.divisor;
      neg_d  = req_i.dividend[31] ^ req_i.divisor[31];
      busy_d = 1'b1;
      cnt_d  = 6'd32;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

endmodule

// ----- rtl/multi_axis_step_generator.sv -----
// Top level of the multi-axis step generator: DDA axes, speed ramp and sequencer.
// A load passes the Delta, Load and Out states before its result is registered; a tick
// passes Axes, Accel and Out, with Div between Accel and Out when the interval update
// needs a division by the shared one-bit-per-cycle divider.
// One item is in work at a time; the output register frees the input side as
// soon as the result is taken. Reset (rst_ni low, asynchronous) clears all state but the divider's data registers.
module multi_axis_step_generator #(
  parameter int unsigned PosWidth = masg_pkg::DefPosWidth,
  parameter int unsigned FracBits = masg_pkg::DefFracBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: target_x, target_y, target_z, target_e, start_interval,
  // end_interval, start_count (from bit 0 up)
  input  logic [223:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // item kind: 0 load, 1 tick
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: step_bits, dir_bits, timer_period, move_done (from bit 0 up), zero fill
  output logic [39:0] m_axis_tdata
);
  import masg_pkg::*;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StDelta = 7'b0000010,
    StLoad  = 7'b0000100,
    StAxes  = 7'b0001000,
    StAccel = 7'b0010000,
    StDiv   = 7'b0100000,
    StOut   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]          amode_q;
  logic [PosWidth-1:0] pos_q [NumAxes];
  logic [PosWidth-1:0] endp_q [NumAxes];
  logic [PosWidth-1:0] dlt_q [NumAxes];
  logic [PosWidth+1:0] err_q [NumAxes];
  logic [PosWidth-1:0] tot_q;
  logic [3:0]          dir_q, steps_q;
  logic [31:0]         ivl_q, lim_q, cnt_q, sidx_q, rlen_q;
  logic [1:0]          phase_q;
  logic                acc_q, act_q, kind_q;
  logic [223:0]        item_q;
  logic                ovalid_q;
  logic [39:0]         odata_q;

  div_req_t dreq;
  div_rsp_t drsp;

  masg_divider u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  // Target fields of the held item, low PosWidth bits.
  logic [PosWidth-1:0] tgt [NumAxes];
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      tgt[i] = item_q[32*i +: PosWidth];
    end
  end

  // Combinational helpers for the load path.
  logic [PosWidth:0]   dsub [NumAxes];
  logic [PosWidth-1:0] dabs [NumAxes];
  logic [PosWidth-1:0] pos_l [NumAxes];
  logic [PosWidth-1:0] tmax;
  always_comb begin
    tmax = dlt_q[0];
    for (int i = 0; i < NumAxes; i++) begin
      pos_l[i] = (i == NumAxes - 1) ? '0 : pos_q[i];
      dsub[i]  = {tgt[i][PosWidth-1], tgt[i]} - {pos_l[i][PosWidth-1], pos_l[i]};
      dabs[i]  = dsub[i][PosWidth] ? PosWidth'(({(PosWidth+1){1'b0}} - dsub[i]))
                                   : dsub[i][PosWidth-1:0];
      if (dlt_q[i] > tmax) tmax = dlt_q[i];
    end
  end

  // Tick-path helpers.
  logic [PosWidth+1:0] err_sub [NumAxes];
  logic [3:0]          step_vec;
  always_comb begin
    for (int i = 0; i < NumAxes; i++) begin
      err_sub[i]  = err_q[i] - {2'b0, dlt_q[i]};
      step_vec[i] = act_q && (pos_q[i] != endp_q[i]) && err_sub[i][PosWidth+1];
    end
  end

  logic [31:0] cnt_ramp, div_num, div_den;
  logic        rst_phase_down, need_div;
  always_comb begin
    rst_phase_down = (phase_q != PhaseDown) && (sidx_q >= rlen_q);
    cnt_ramp = (rst_phase_down ? (32'hFFFF_FFFE - cnt_q) : cnt_q) + 32'd4;
    div_num  = {ivl_q[30:0], 1'b0};
    div_den  = (amode_q == AccelRamp) ? cnt_ramp : cnt_q;
  end

  logic [31:0] new_ivl;
  assign new_ivl = ivl_q - drsp.quotient;

  // Done flag of the result and the end of a move on a tick without steps.
  logic out_done, out_finish;
  assign out_finish = (kind_q == ItemTick) && act_q && (steps_q == '0);
  assign out_done   = (kind_q == ItemLoad) ? !act_q : (!act_q || steps_q == '0);

  always_comb begin
    need_div = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = div_num;
    dreq.divisor  = div_den;
    if (state_q == StAccel && act_q && kind_q == ItemTick) begin
      if (amode_q == AccelCount) begin
        need_div = acc_q && ((!cnt_q[31] && cnt_q != 0 && ivl_q > lim_q) ||
                             (cnt_q[31] && ivl_q < lim_q));
      end else if (amode_q == AccelRamp) begin
        need_div = (phase_q != PhaseMax) || rst_phase_down;
      end
    end
    dreq.start = need_div && (div_den != 0);
  end

  assign s_axis_tready = (state_q == StIdle) && !ovalid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (s_axis_tvalid && s_axis_tready)
                 state_d = s_axis_tuser ? StAxes : StDelta;
      StDelta: state_d = StLoad;
      StLoad:  state_d = StOut;
      StAxes:  state_d = StAccel;
      StAccel: state_d = dreq.start ? StDiv : StOut;
      StDiv:   if (drsp.done) state_d = StOut;
      StOut:   if (!ovalid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Control and datapath registers, updated by the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      amode_q  <= AccelConst;
      for (int i = 0; i < NumAxes; i++) begin
        pos_q[i] <= '0; endp_q[i] <= '0; dlt_q[i] <= '0; err_q[i] <= '0;
      end
      tot_q <= '0; dir_q <= '0; steps_q <= '0;
      ivl_q <= '0; lim_q <= '0; cnt_q <= '0; sidx_q <= '0; rlen_q <= '0;
      phase_q <= PhaseUp; acc_q <= 1'b0; act_q <= 1'b0;
      kind_q <= ItemLoad; item_q <= '0;
      ovalid_q <= 1'b0; odata_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) amode_q <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && s_axis_tready) begin
            item_q <= s_axis_tdata;
            kind_q <= s_axis_tuser;
          end
        end
        StDelta: begin
          pos_q[NumAxes-1] <= '0;
          for (int i = 0; i < NumAxes; i++) begin
            endp_q[i] <= tgt[i];
            dlt_q[i]  <= dabs[i];
            dir_q[i]  <= ~dsub[i][PosWidth];
          end
        end
        StLoad: begin
          tot_q <= tmax;
          for (int i = 0; i < NumAxes; i++)
            err_q[i] <= {(PosWidth+2){1'b0}} - {3'b0, tmax[PosWidth-1:1]};
          ivl_q  <= item_q[128 +: 32];
          lim_q  <= item_q[160 +: 32];
          acc_q  <= item_q[128 +: 32] != item_q[160 +: 32];
          cnt_q  <= (amode_q == AccelRamp) ? 32'd1 : item_q[192 +: 32];
          sidx_q <= '0;
          rlen_q <= 32'(tmax >> 1) + 32'(tmax[0]);
          phase_q <= PhaseUp;
          act_q  <= tmax != 0;
          steps_q <= '0;
        end
        StAxes: begin
          steps_q <= step_vec;
          if (act_q) begin
            for (int i = 0; i < NumAxes; i++) begin
              if (pos_q[i] != endp_q[i]) begin
                if (step_vec[i]) begin
                  pos_q[i]   <= dir_q[i] ? pos_q[i] + 1'b1 : pos_q[i] - 1'b1;
                  err_q[i]   <= err_sub[i] + {2'b0, tot_q};
                end else begin
                  err_q[i] <= err_sub[i];
                end
              end
            end
          end
        end
        StAccel: begin
          if (act_q) begin
            if (amode_q == AccelCount && acc_q) begin
              if (need_div) begin
                cnt_q <= cnt_q + 32'd4;
              end else if (ivl_q != lim_q) begin
                ivl_q <= lim_q;
              end
            end else if (amode_q == AccelRamp) begin
              if (need_div) cnt_q <= cnt_ramp;
              if (need_div && div_den == 0 && ivl_q <= lim_q) begin
                ivl_q   <= lim_q;
                phase_q <= PhaseMax;
                rlen_q  <= 32'(tot_q) - sidx_q;
              end else if (rst_phase_down) begin
                phase_q <= PhaseDown;
              end
              sidx_q <= sidx_q + 32'd1;
            end
          end
        end
        StDiv: begin
          if (drsp.done) begin
            if (amode_q == AccelRamp && new_ivl <= lim_q) begin
              ivl_q   <= lim_q;
              phase_q <= PhaseMax;
              rlen_q  <= 32'(tot_q) - (sidx_q - 32'd1);
            end else begin
              ivl_q <= new_ivl;
            end
          end
        end
        StOut: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            odata_q  <= {7'b0, out_done, PeriodWidth'(ivl_q >> FracBits), dir_q, steps_q};
            if (out_finish) begin
              act_q <= 1'b0;
              pos_q[NumAxes-1] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// ----- rtl/masg_checker.sv -----
// Port-level checker for the multi-axis step generator, bound to the top level.
module masg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);
  // A result that waits holds its data.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No input is taken while a result waits.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("ready while result pending");

  // After an accepted transfer the block is busy next cycle.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after transfer");

  // A result with steps never reports done.
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:0] != 4'd0 |-> !m_axis_tdata[32])
    else $error("done with steps");
endmodule

bind multi_axis_step_generator masg_checker u_masg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
